### hw/rtl/rrts_pkg.sv
// Package with types and constants shared by the thread scheduler modules.
`default_nettype none
package rrts_pkg;
	localparam int SLOTS = 16;
	localparam int SW = 4;
	localparam int CW = 5;

	localparam logic [2:0] ST_CREATED = 3'd0;
	localparam logic [2:0] ST_READY = 3'd1;
	localparam logic [2:0] ST_RUNNING = 3'd2;
	localparam logic [2:0] ST_BLOCKED = 3'd3;
	localparam logic [2:0] ST_TERMINATED = 3'd4;
	localparam logic [2:0] ST_IDLE = 3'd5;

	localparam logic [2:0] OP_TICK = 3'd0;
	localparam logic [2:0] OP_YIELD = 3'd1;
	localparam logic [2:0] OP_CREATE = 3'd2;
	localparam logic [2:0] OP_BLOCK = 3'd3;
	localparam logic [2:0] OP_UNBLOCK = 3'd4;
	localparam logic [2:0] OP_EXIT = 3'd5;

	localparam logic [1:0] STS_OK = 2'd0;
	localparam logic [1:0] STS_NOSLOT = 2'd1;
	localparam logic [1:0] STS_IGNORED = 2'd2;

	localparam logic [SW-1:0] IDLE_SLOT = SW'(1);
	localparam logic [0:0] REG_ENABLED = 1'b0;
	localparam logic [0:0] REG_TIMESLICE = 1'b1;
	localparam logic [31:0] ID_RESTART = 32'd3;

	typedef struct packed {
		logic [2:0] opcode;
		logic [3:0] target_slot;
		logic target_is_current;
	} in_t;

	typedef struct packed {
		logic [3:0] running_slot;
		logic switched;
		logic [3:0] new_slot;
		logic [31:0] new_id;
		logic [1:0] status;
	} out_t;

	// Queue cell commands: pop drops the head; remove drops the first match.
	typedef struct packed {
		logic push;
		logic [SW-1:0] push_slot;
		logic pop;
		logic remove;
		logic [SW-1:0] remove_slot;
	} qcmd_t;
endpackage
`default_nettype wire

### hw/rtl/round_robin_thread_scheduler.sv
// Top level of the round-robin thread scheduler.
// A transaction passes through the idle, execute, push and output states in turn. The
// idle state accepts and captures the event. The execute state applies the queue
// operation and, on a scheduling event or an exit, reclaims terminated slots. The push
// state re-enqueues a preempted thread and forms the result. The output state presents
// the result and holds it while the output is stalled. The next event is accepted in
// the cycle after the result leaves. The ready queue is a chain of sixteen cells that
// shift toward the head, so every queue operation updates all cells together. One
// transaction is in flight at a time.
`default_nettype none
module round_robin_thread_scheduler (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire rrts_pkg::in_t in_data,
	output logic out_valid,
	input wire logic out_stall,
	output rrts_pkg::out_t out_data,
	input wire logic cfg_we,
	input wire logic [0:0] cfg_index,
	input wire logic [7:0] cfg_data
);
	import rrts_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_PUSH = 2'd2;
	localparam logic [1:0] S_OUT = 2'd3;

	logic [1:0] state_q;
	logic enabled_q;
	logic [7:0] tslice_q;
	logic [2:0] sst_q [SLOTS];
	logic [SLOTS-1:0] act_q;
	logic [7:0] used_q [SLOTS];
	logic [SW-1:0] cur_q;
	logic [SW-1:0] before_q;
	logic [31:0] nid_q;
	in_t op_q;
	out_t res_q;
	logic [SW-1:0] pend_q;
	logic pend_push_q;

	qcmd_t cmd;
	logic [SW-1:0] head;
	logic [CW-1:0] count;

	rrts_queue u_queue (.clk(clk), .arst_n(arst_n), .cmd(cmd), .head(head), .count(count));

	logic found;
	logic [SW-1:0] free_slot;
	always_comb begin
		found = 1'b0;
		free_slot = '0;
		for (int i = SLOTS-1; i >= 2; i--) begin
			if (!act_q[i]) begin
				found = 1'b1;
				free_slot = SW'(i);
			end
		end
	end

	logic [7:0] used_inc;
	assign used_inc = (used_q[cur_q] == 8'hff) ? 8'hff : used_q[cur_q] + 8'd1;
	logic [SW-1:0] blk_t;
	assign blk_t = op_q.target_is_current ? cur_q : op_q.target_slot;

	// Decisions for the execute cycle.
	logic do_sched, do_exit;
	logic [2:0] cur_st_eff;
	always_comb begin
		do_sched = 1'b0;
		do_exit = 1'b0;
		cur_st_eff = sst_q[cur_q];
		case (op_q.opcode)
			OP_TICK: do_sched = enabled_q && ((used_inc >= tslice_q) ||
				(cur_q == IDLE_SLOT && count != '0));
			OP_YIELD: do_sched = enabled_q;
			OP_BLOCK: if (blk_t == cur_q) begin
				do_sched = enabled_q;
				cur_st_eff = ST_BLOCKED;
			end
			OP_EXIT: begin
				do_exit = 1'b1;
				cur_st_eff = ST_TERMINATED;
			end
			default: ;
		endcase
	end

	logic go_next;
	logic [SW-1:0] next_slot;
	logic pop_it;
	always_comb begin
		go_next = 1'b0;
		next_slot = IDLE_SLOT;
		pop_it = 1'b0;
		if (do_exit) begin
			go_next = 1'b1;
			pop_it = (count != '0);
			next_slot = pop_it ? head : IDLE_SLOT;
		end else if (do_sched) begin
			if (count == '0) begin
				go_next = !(cur_st_eff == ST_RUNNING || cur_st_eff == ST_READY) &&
					(cur_q != IDLE_SLOT);
				next_slot = IDLE_SLOT;
			end else begin
				pop_it = 1'b1;
				next_slot = head;
				go_next = (head != cur_q);
			end
		end
	end

	always_comb begin
		cmd = '0;
		if (state_q == S_EXEC) begin
			cmd.pop = pop_it;
			case (op_q.opcode)
				OP_CREATE: begin
					cmd.push = found;
					cmd.push_slot = free_slot;
				end
				OP_BLOCK: begin
					cmd.remove = (blk_t != cur_q);
					cmd.remove_slot = blk_t;
				end
				OP_UNBLOCK: begin
					cmd.push = (sst_q[op_q.target_slot] == ST_BLOCKED);
					cmd.push_slot = op_q.target_slot;
				end
				default: ;
			endcase
		end else if (state_q == S_PUSH) begin
			cmd.push = pend_push_q;
			cmd.push_slot = pend_q;
		end
	end

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign out_data = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			enabled_q <= 1'b0;
			tslice_q <= 8'd10;
			act_q <= SLOTS'(3);
			cur_q <= '0;
			nid_q <= ID_RESTART;
			pend_push_q <= 1'b0;
			for (int i = 0; i < SLOTS; i++) begin
				sst_q[i] <= (i == 0) ? ST_RUNNING : ((i == 1) ? ST_IDLE : ST_CREATED);
				used_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_ENABLED) enabled_q <= cfg_data[0];
				else tslice_q <= cfg_data;
			end
			case (state_q)
				S_IDLE: if (in_valid) begin
					op_q <= in_data;
					before_q <= cur_q;
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					res_q <= '0;
					pend_push_q <= 1'b0;
					state_q <= S_PUSH;
					if (op_q.opcode == OP_TICK && enabled_q) used_q[cur_q] <= used_inc;
					if (do_sched || do_exit) begin
						for (int i = 0; i < SLOTS; i++) begin
							if (act_q[i] && SW'(i) != cur_q && sst_q[i] == ST_TERMINATED)
								act_q[i] <= 1'b0;
						end
					end
					case (op_q.opcode)
						OP_TICK, OP_YIELD: if (!enabled_q) res_q.status <= STS_IGNORED;
						OP_CREATE: if (!found || count == CW'(SLOTS)) begin
							res_q.status <= STS_NOSLOT;
						end else begin
							res_q.new_slot <= free_slot;
							res_q.new_id <= nid_q;
						end
						OP_BLOCK: if (blk_t != cur_q) sst_q[blk_t] <= ST_BLOCKED;
						OP_UNBLOCK: if (sst_q[op_q.target_slot] == ST_BLOCKED) begin
							sst_q[op_q.target_slot] <= ST_READY;
						end else begin
							res_q.status <= STS_IGNORED;
						end
						OP_EXIT: ;
						default: res_q.status <= STS_IGNORED;
					endcase
					if (op_q.opcode == OP_CREATE && found) begin
						nid_q <= (nid_q == 32'hffff_ffff) ? ID_RESTART : nid_q + 32'd1;
						sst_q[free_slot] <= ST_READY;
						used_q[free_slot] <= '0;
						act_q[free_slot] <= (count != CW'(SLOTS));
					end
					if (do_exit || do_sched) begin
						if (go_next) begin
							if (!do_exit && cur_st_eff == ST_RUNNING) begin
								if (cur_q != IDLE_SLOT) begin
									sst_q[cur_q] <= ST_READY;
									pend_push_q <= 1'b1;
									pend_q <= cur_q;
								end else begin
									sst_q[cur_q] <= ST_IDLE;
								end
							end else begin
								sst_q[cur_q] <= cur_st_eff;
							end
							sst_q[next_slot] <= ST_RUNNING;
							used_q[next_slot] <= '0;
							cur_q <= next_slot;
						end else begin
							sst_q[cur_q] <= (cur_st_eff == ST_RUNNING ||
								cur_st_eff == ST_READY || pop_it || cur_q == IDLE_SLOT)
								? ST_RUNNING : cur_st_eff;
						end
					end else if (op_q.opcode == OP_BLOCK && blk_t == cur_q) begin
						sst_q[cur_q] <= ST_BLOCKED;
					end
				end
				S_PUSH: begin
					pend_push_q <= 1'b0;
					res_q.running_slot <= cur_q;
					res_q.switched <= (cur_q != before_q);
					state_q <= S_OUT;
				end
				S_OUT: if (!out_stall) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

### hw/rtl/rrts_qcell.sv
// One entry of the ready queue chain, holding a slot index and a valid bit.
`default_nettype none
module rrts_qcell (
	input wire logic clk,
	input wire logic arst_n,
	input wire rrts_pkg::qcmd_t cmd,
	input wire logic prev_valid,
	input wire logic prev_match_seen,
	input wire logic next_valid,
	input wire logic [rrts_pkg::SW-1:0] next_slot,
	input wire logic is_tail,
	output logic valid,
	output logic [rrts_pkg::SW-1:0] slot,
	output logic match_seen
);
	import rrts_pkg::*;
	logic valid_q;
	logic [SW-1:0] slot_q;
	logic shift;

	assign valid = valid_q;
	assign slot = slot_q;
	assign match_seen = prev_match_seen | (valid_q & (slot_q == cmd.remove_slot));
	assign shift = cmd.pop | (cmd.remove & match_seen);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= next_valid;
		end else if (cmd.push && !valid_q && prev_valid) begin
			valid_q <= 1'b1;
		end else if (cmd.push && !valid_q && is_tail) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			slot_q <= next_slot;
		end else if (cmd.push && !valid_q && (prev_valid || is_tail)) begin
			slot_q <= cmd.push_slot;
		end
	end
endmodule
`default_nettype wire

### hw/rtl/rrts_queue.sv
// Ready queue built as a chain of cells that shift toward the head.
`default_nettype none
module rrts_queue (
	input wire logic clk,
	input wire logic arst_n,
	input wire rrts_pkg::qcmd_t cmd,
	output logic [rrts_pkg::SW-1:0] head,
	output logic [rrts_pkg::CW-1:0] count
);
	import rrts_pkg::*;
	logic [SLOTS-1:0] v;
	logic [SLOTS-1:0] ms;
	logic [SW-1:0] s [SLOTS];
	logic [CW-1:0] count_q;

	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		rrts_qcell u_cell (
			.clk(clk), .arst_n(arst_n), .cmd(cmd),
			.prev_valid(i == 0 ? 1'b0 : v[(i == 0) ? 0 : i-1]),
			.prev_match_seen(i == 0 ? 1'b0 : ms[(i == 0) ? 0 : i-1]),
			.next_valid(i == SLOTS-1 ? 1'b0 : v[(i == SLOTS-1) ? i : i+1]),
			.next_slot(s[(i == SLOTS-1) ? i : i+1]),
			.is_tail(i == 0),
			.valid(v[i]), .slot(s[i]), .match_seen(ms[i])
		);
	end

	assign head = s[0];
	assign count = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_q + CW'(cmd.push && !v[SLOTS-1])
				- CW'(cmd.pop || (cmd.remove && ms[SLOTS-1]));
		end
	end
endmodule
`default_nettype wire

### hw/rtl/rrts_checker.sv
// Port checker for the thread scheduler and its bind statement.
`default_nettype none
module rrts_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_stall,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire rrts_pkg::out_t out_data
);
	import rrts_pkg::*;
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data)) else $error("hold");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.status != 2'd3) else $error("status");
	a_newslot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != STS_OK |-> out_data.new_slot == '0)
		else $error("new_slot");
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("overlap");
endmodule

bind round_robin_thread_scheduler rrts_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data));
`default_nettype wire
